// File: src/mbdd_pkg.sv
// Package for the magnetic baseline disturbance detector.
// Holds register indexes, reset defaults, field widths and the event codes.
// No dependencies.
package mbdd_pkg;

  // Default sample width of one axis.
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Width of the limit registers and the quiet counter.
  localparam int LIMIT_W = 16;
  localparam int QUIET_W = 16;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_OVER_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CALM_LIMIT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_QUIET_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_RECAL  = 3'd4;

  // Register values after reset.
  localparam logic [LIMIT_W-1:0] OVER_LIMIT_RST  = 16'd1000;
  localparam logic [LIMIT_W-1:0] CALM_LIMIT_RST  = 16'd300;
  localparam logic [LIMIT_W-1:0] DELTA_LIMIT_RST = 16'd30;
  localparam logic [LIMIT_W-1:0] QUIET_LIMIT_RST = 16'd10;
  localparam logic               AUTO_RECAL_RST  = 1'b1;

  // Classification of one sample.
  typedef enum logic [1:0] {
    KIND_STEADY    = 2'd0,
    KIND_OVER      = 2'd1,
    KIND_CAPTURE   = 2'd2,
    KIND_DEVIATION = 2'd3
  } event_kind_t;

  // Output stream widths.
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;

endpackage

// File: src/magnetic_baseline_disturbance_detector.sv
// Magnetic baseline disturbance detector: one three-axis sample per beat.
// Each sample is held in the input register, then in the result register.
// One sample per cycle while the result stream is not stalled by m_tready.
// Reset (rst, synchronous): registers return to defaults, baseline clears to zero,
// calibration is pending, the quiet counter is zero and both pipeline stages empty.
// Depends on mbdd_pkg.
module magnetic_baseline_disturbance_detector #(
  parameter int SAMPLE_WIDTH = mbdd_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_DATA_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sample stream in.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata: axis_x, axis_y, axis_z (SAMPLE_WIDTH bits each), zero pad.
  input  logic [IN_DATA_W-1:0]                s_tdata,
  // Result stream out.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata: bit 0 disturbed, bit 1 cal_pending, zero pad.
  output logic [mbdd_pkg::OUT_DATA_W-1:0]     m_tdata,
  // tuser: event_kind.
  output logic [mbdd_pkg::OUT_USER_W-1:0]     m_tuser,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbdd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int LW = mbdd_pkg::LIMIT_W;
  // Compare width: holds a magnitude of a baseline difference and any limit.
  localparam int MW = (SW >= LW) ? SW + 1 : LW + 1;

  // Configuration registers.
  logic [LW-1:0] over_limit;
  logic [LW-1:0] calm_limit;
  logic [LW-1:0] delta_limit;
  logic [LW-1:0] quiet_limit;
  logic          auto_recal_enable;

  // Detector state.
  logic signed [SW-1:0]           base [3];
  logic                           need_cal;
  logic [mbdd_pkg::QUIET_W-1:0]   quiet_count;

  // Input stage.
  logic                 s1_valid;
  logic signed [SW-1:0] s1_axis [3];

  // Result stage.
  logic                  out_valid;
  logic                  out_disturbed;
  logic                  out_cal_pending;
  mbdd_pkg::event_kind_t out_kind;

  logic advance;

  // Combinational results for the sample in the input stage.
  logic signed [SW-1:0]         base_next [3];
  logic                         need_cal_next;
  logic [mbdd_pkg::QUIET_W-1:0] quiet_count_next;
  logic                         disturbed_next;
  mbdd_pkg::event_kind_t        kind_next;

  assign cfg_ready = 1'b1;

  // Input stage moves on when the result stage is empty or being drained.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !s1_valid || advance;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      over_limit        <= mbdd_pkg::OVER_LIMIT_RST;
      calm_limit        <= mbdd_pkg::CALM_LIMIT_RST;
      delta_limit       <= mbdd_pkg::DELTA_LIMIT_RST;
      quiet_limit       <= mbdd_pkg::QUIET_LIMIT_RST;
      auto_recal_enable <= mbdd_pkg::AUTO_RECAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbdd_pkg::REG_OVER_LIMIT:  over_limit        <= cfg_data;
        mbdd_pkg::REG_CALM_LIMIT:  calm_limit        <= cfg_data;
        mbdd_pkg::REG_DELTA_LIMIT: delta_limit       <= cfg_data;
        mbdd_pkg::REG_QUIET_LIMIT: quiet_limit       <= cfg_data;
        mbdd_pkg::REG_AUTO_RECAL:  auto_recal_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < 3; i++) begin
        s1_axis[i] <= s_tdata[i*SW +: SW];
      end
    end
  end

  // Classification and state update for the sample in the input stage.
  always_comb begin
    logic signed [MW-1:0] xe;
    logic signed [MW-1:0] be;
    logic signed [MW-1:0] diff;
    logic [MW-1:0]        mag;
    logic [MW-1:0]        dmag;
    logic [MW-1:0]        over_e;
    logic [MW-1:0]        calm_e;
    logic [MW-1:0]        delta_e;
    logic                 any_over;
    logic                 all_calm;
    logic                 any_dev;
    logic [mbdd_pkg::QUIET_W-1:0] quiet_inc;

    over_e   = {{(MW-LW){1'b0}}, over_limit};
    calm_e   = {{(MW-LW){1'b0}}, calm_limit};
    delta_e  = {{(MW-LW){1'b0}}, delta_limit};
    any_over = 1'b0;
    all_calm = 1'b1;
    any_dev  = 1'b0;

    // Per-axis magnitudes and deviations from the baseline.
    for (int i = 0; i < 3; i++) begin
      xe   = {{(MW-SW){s1_axis[i][SW-1]}}, s1_axis[i]};
      be   = {{(MW-SW){base[i][SW-1]}}, base[i]};
      mag  = xe[MW-1] ? MW'(-xe) : MW'(xe);
      diff = be - xe;
      dmag = diff[MW-1] ? MW'(-diff) : MW'(diff);
      if (mag > over_e) begin
        any_over = 1'b1;
      end
      if (!(mag < calm_e)) begin
        all_calm = 1'b0;
      end
      if (dmag > delta_e) begin
        any_dev = 1'b1;
      end
    end

    quiet_inc        = quiet_count + 1'b1;
    base_next        = base;
    need_cal_next    = need_cal;
    quiet_count_next = quiet_count;
    disturbed_next   = 1'b0;
    kind_next        = mbdd_pkg::KIND_STEADY;

    if (any_over) begin
      need_cal_next  = 1'b1;
      disturbed_next = 1'b1;
      kind_next      = mbdd_pkg::KIND_OVER;
    end else if (need_cal && all_calm) begin
      base_next     = s1_axis;
      need_cal_next = 1'b0;
      kind_next     = mbdd_pkg::KIND_CAPTURE;
    end else if (any_dev) begin
      if (auto_recal_enable) begin
        quiet_count_next = '0;
      end
      disturbed_next = 1'b1;
      kind_next      = mbdd_pkg::KIND_DEVIATION;
    end else if (auto_recal_enable) begin
      // Long quiet run: ask for a new baseline and restart the count.
      if (quiet_inc > quiet_limit) begin
        need_cal_next    = 1'b1;
        quiet_count_next = '0;
      end else begin
        quiet_count_next = quiet_inc;
      end
    end
  end

  // State update, one sample per cycle whenever the input stage advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        base[i] <= '0;
      end
      need_cal    <= 1'b1;
      quiet_count <= '0;
    end else if (s1_valid && advance) begin
      base        <= base_next;
      need_cal    <= need_cal_next;
      quiet_count <= quiet_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_disturbed   <= disturbed_next;
      out_cal_pending <= need_cal_next;
      out_kind        <= kind_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(mbdd_pkg::OUT_DATA_W-2){1'b0}}, out_cal_pending, out_disturbed};
  assign m_tuser  = out_kind;

  // A captured baseline always clears the pending calibration.
  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == mbdd_pkg::KIND_CAPTURE) |-> !m_tdata[1])
    else $error("baseline capture reported with calibration still pending");

  // An over-range sample is disturbed and requests calibration.
  a_over_requests: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == mbdd_pkg::KIND_OVER) |-> (m_tdata[0] && m_tdata[1]))
    else $error("over-range sample without disturbance or calibration request");

  // The disturbed flag matches the event kind.
  a_disturbed_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tuser == mbdd_pkg::KIND_OVER ||
                                 m_tuser == mbdd_pkg::KIND_DEVIATION)))
    else $error("disturbed flag disagrees with event kind");

  // A captured baseline leaves the quiet counter untouched.
  a_capture_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && kind_next == mbdd_pkg::KIND_CAPTURE) |=>
      $stable(quiet_count))
    else $error("quiet counter changed on baseline capture");

endmodule

// File: tb/testbench.sv
// Self-checking bench for the magnetic baseline disturbance detector.
// It predicts every result beat in step with the input handshakes and checks each one.
// Depends on mbdd_pkg and magnetic_baseline_disturbance_detector.
module testbench;

  localparam int AXIS_W = mbdd_pkg::SAMPLE_WIDTH_DEF;
  localparam int BEAT_W = ((3 * AXIS_W + 7) / 8) * 8;
  localparam int PIPE_DEPTH = 2;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 215;
  localparam int RUN_SAMPLES = 20;
  localparam logic [mbdd_pkg::CFG_INDEX_W-1:0] REG_LAST = mbdd_pkg::REG_AUTO_RECAL;

  // One predicted result beat.
  typedef struct packed {
    logic                  disturbed;
    mbdd_pkg::event_kind_t kind;
    logic                  cal_pending;
  } verdict_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [BEAT_W-1:0]                s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [mbdd_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic [mbdd_pkg::OUT_USER_W-1:0]  m_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mbdd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mbdd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Stimulus and scoreboard storage.
  logic [BEAT_W-1:0] sample_queue[$];
  verdict_t          pending_results[$];
  int                mismatch_count = 0;
  bit                in_fire = 1'b0;
  bit                full_rate = 1'b0;
  int                burst_left = 1;
  int                gap_left = 0;
  logic [15:0]       rx_tick = '0;

  // Predictor state: registers, baseline, calibration request and quiet counter.
  logic [mbdd_pkg::LIMIT_W-1:0] lim_over, lim_calm, lim_delta, lim_quiet;
  logic                         auto_en;
  int                           bl_x, bl_y, bl_z;
  logic                         recal_due;
  logic [mbdd_pkg::QUIET_W-1:0] calm_run;

  // Generator anchor: the last calm sample drawn, a guess at the current baseline.
  int near_x = 0, near_y = 0, near_z = 0;

  magnetic_baseline_disturbance_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Classify one sample and advance the predicted detector state.
  function automatic verdict_t classify_sample(logic [BEAT_W-1:0] beat);
    logic signed [AXIS_W-1:0] rx, ry, rz;
    int sx, sy, sz, ax, ay, az, hi, lo, dl;
    verdict_t v;
    rx = beat[AXIS_W-1:0];
    ry = beat[2*AXIS_W-1:AXIS_W];
    rz = beat[3*AXIS_W-1:2*AXIS_W];
    sx = rx;
    sy = ry;
    sz = rz;
    ax = abs_int(sx);
    ay = abs_int(sy);
    az = abs_int(sz);
    hi = lim_over;
    lo = lim_calm;
    dl = lim_delta;
    v.disturbed = 1'b0;
    v.kind = mbdd_pkg::KIND_STEADY;
    if (ax > hi || ay > hi || az > hi) begin
      recal_due = 1'b1;
      v.disturbed = 1'b1;
      v.kind = mbdd_pkg::KIND_OVER;
    end else if (recal_due && ax < lo && ay < lo && az < lo) begin
      bl_x = sx;
      bl_y = sy;
      bl_z = sz;
      recal_due = 1'b0;
      v.kind = mbdd_pkg::KIND_CAPTURE;
    end else if (abs_int(bl_x - sx) > dl || abs_int(bl_y - sy) > dl ||
                 abs_int(bl_z - sz) > dl) begin
      if (auto_en) calm_run = '0;
      v.disturbed = 1'b1;
      v.kind = mbdd_pkg::KIND_DEVIATION;
    end else if (auto_en) begin
      // The counter wraps before the compare.
      calm_run = calm_run + 1'b1;
      if (calm_run > lim_quiet) begin
        recal_due = 1'b1;
        calm_run = '0;
      end
    end
    v.cal_pending = recal_due;
    return v;
  endfunction

  // Clamp to the signed axis range.
  function automatic logic [AXIS_W-1:0] to_axis(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[AXIS_W-1:0];
  endfunction

  function automatic void queue_sample(int x, int y, int z);
    sample_queue.push_back({to_axis(z), to_axis(y), to_axis(x)});
  endfunction

  function automatic int jitter(int d);
    return int'($urandom_range(0, 2 * d)) - d;
  endfunction

  // Values on the threshold boundaries of the current settings.
  function automatic int corner_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return int'(lim_over);
      2: return -int'(lim_over);
      3: return int'(lim_over) + 1;
      4: return -(int'(lim_over) + 1);
      5: return int'(lim_calm) - 1;
      6: return -int'(lim_calm);
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
  endfunction

  // Half the samples near the baseline anchor, with calm, over-range, boundary and full-range samples mixed in.
  function automatic logic [BEAT_W-1:0] draw_sample();
    int pick, d, c, o, off, x, y, z;
    pick = $urandom_range(0, 99);
    d = (lim_delta > 3000) ? 3000 : int'(lim_delta);
    x = near_x;
    y = near_y;
    z = near_z;
    if (pick < 35) begin
      x += jitter(d);
      y += jitter(d);
      z += jitter(d);
    end else if (pick < 50) begin
      // One axis right at, or one past, the allowed deviation.
      x += jitter(d);
      y += jitter(d);
      z += jitter(d);
      off = int'(lim_delta) + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) off = -off;
      case ($urandom_range(0, 2))
        0: x = near_x + off;
        1: y = near_y + off;
        default: z = near_z + off;
      endcase
    end else if (pick < 65) begin
      c = (lim_calm == 0) ? 0 : int'(lim_calm) - 1;
      if (c > 32767) c = 32767;
      x = jitter(c);
      y = jitter(c);
      z = jitter(c);
      near_x = x;
      near_y = y;
      near_z = z;
    end else if (pick < 75) begin
      c = (lim_over > 32767) ? 32767 : int'(lim_over);
      x = jitter(c);
      y = jitter(c);
      z = jitter(c);
      o = int'(lim_over) + 1 + int'($urandom_range(0, 50));
      if ($urandom_range(0, 1)) o = -o;
      case ($urandom_range(0, 2))
        0: x = o;
        1: y = o;
        default: z = o;
      endcase
    end else if (pick < 87) begin
      x = corner_value();
      y = corner_value();
      z = corner_value();
    end else begin
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      z = int'($urandom_range(0, 65535)) - 32768;
    end
    return {to_axis(z), to_axis(y), to_axis(x)};
  endfunction

  task automatic field_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // Register write on the configuration channel; returns after the accepted beat.
  task automatic write_reg(logic [mbdd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [mbdd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block until every queued sample is sent and every result has come back.
  task automatic wait_drained();
    while (sample_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Sample driver: bursts of beats with random gaps between them, or back to back at full rate.
  always @(negedge clk) begin : sample_driver
    logic              nv;
    logic [BEAT_W-1:0] nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || in_fire) begin
      nv = 1'b0;
      if (!full_rate && gap_left > 0) begin
        gap_left--;
      end else if (sample_queue.size() != 0) begin
        nv = 1'b1;
        nd = sample_queue.pop_front();
        if (!full_rate) begin
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
  end

  // Result back-pressure: ready at full rate, else cycles through ready, random, mostly ready, mostly stalled.
  always @(negedge clk) begin : result_stall
    rx_tick <= rx_tick + 1'b1;
    if (full_rate) begin
      m_tready <= 1'b1;
    end else begin
      case (rx_tick[8:7])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= (rx_tick[2:0] != 3'd0);
        default: m_tready <= (rx_tick[2:0] == 3'd0);
      endcase
    end
  end

  // Predict on every accepted sample beat and check every accepted result beat.
  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (rst) begin
      lim_over = mbdd_pkg::OVER_LIMIT_RST;
      lim_calm = mbdd_pkg::CALM_LIMIT_RST;
      lim_delta = mbdd_pkg::DELTA_LIMIT_RST;
      lim_quiet = mbdd_pkg::QUIET_LIMIT_RST;
      auto_en = mbdd_pkg::AUTO_RECAL_RST;
      bl_x = 0;
      bl_y = 0;
      bl_z = 0;
      recal_due = 1'b1;
      calm_run = '0;
      in_fire = 1'b0;
    end else begin
      in_fire = s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mbdd_pkg::REG_OVER_LIMIT:  lim_over = cfg_data;
          mbdd_pkg::REG_CALM_LIMIT:  lim_calm = cfg_data;
          mbdd_pkg::REG_DELTA_LIMIT: lim_delta = cfg_data;
          mbdd_pkg::REG_QUIET_LIMIT: lim_quiet = cfg_data;
          mbdd_pkg::REG_AUTO_RECAL:  auto_en = cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) pending_results.push_back(classify_sample(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          field_mismatch("result beat with nothing pending, kind", m_tuser, 0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[0] !== want.disturbed)
            field_mismatch("disturbed", m_tdata[0], want.disturbed);
          if (m_tdata[1] !== want.cal_pending)
            field_mismatch("cal_pending", m_tdata[1], want.cal_pending);
          if (m_tdata[mbdd_pkg::OUT_DATA_W-1:2] !== '0)
            field_mismatch("tdata pad", m_tdata[mbdd_pkg::OUT_DATA_W-1:2], 0);
          if (m_tuser !== want.kind)
            field_mismatch("event_kind", m_tuser, want.kind);
        end
      end
    end
  end

  // Run sequence: directed checks, a full-rate random run, then random phases.
  initial begin : run_sequence
    logic [mbdd_pkg::CFG_DATA_W-1:0] set_over, set_calm, set_delta, set_quiet;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: capture, exact delta, deviation, over range on each axis.
    queue_sample(100, -50, 20);
    queue_sample(100, -50, 20);
    queue_sample(130, -80, 50);
    queue_sample(131, -50, 20);
    queue_sample(-1000, 1000, 0);
    queue_sample(1001, 0, 0);
    queue_sample(0, -1001, 0);
    queue_sample(0, 0, 1001);
    queue_sample(299, -299, -299);
    queue_sample(300, 0, 0);
    queue_sample(-32768, 0, 0);
    queue_sample(32767, 32767, 32767);
    // A run of steady samples long enough to pass the quiet limit.
    for (int i = 0; i < 13; i++) queue_sample(-299, 0, 0);
    wait_drained();

    // Widest limits; the most negative sample sits exactly on the over limit.
    write_reg(mbdd_pkg::REG_OVER_LIMIT, 16'h8000);
    write_reg(mbdd_pkg::REG_CALM_LIMIT, 16'h8000);
    write_reg(mbdd_pkg::REG_DELTA_LIMIT, 16'hFFFF);
    write_reg(mbdd_pkg::REG_QUIET_LIMIT, 16'h0000);
    write_reg(mbdd_pkg::REG_AUTO_RECAL, 16'hFFFF);
    // Writes past the last register must change nothing.
    for (int i = REG_LAST + 1; i < (1 << mbdd_pkg::CFG_INDEX_W); i++)
      write_reg(mbdd_pkg::CFG_INDEX_W'(i), 16'h0000);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, -32767, 0);
    queue_sample(-32768, 32767, -32768);
    queue_sample(0, 0, 0);
    wait_drained();

    // Zero limits with the quiet counter disabled.
    write_reg(mbdd_pkg::REG_OVER_LIMIT, 16'h0000);
    write_reg(mbdd_pkg::REG_CALM_LIMIT, 16'h0000);
    write_reg(mbdd_pkg::REG_DELTA_LIMIT, 16'h0000);
    write_reg(mbdd_pkg::REG_AUTO_RECAL, 16'hFFFE);
    queue_sample(0, 0, 0);
    queue_sample(1, 0, 0);
    queue_sample(0, -1, 0);
    queue_sample(0, 0, 0);
    wait_drained();

    // Random run at full rate with the widest quiet limit, then a small limit.
    write_reg(mbdd_pkg::REG_OVER_LIMIT, 16'h8000);
    write_reg(mbdd_pkg::REG_DELTA_LIMIT, 16'hFFFF);
    write_reg(mbdd_pkg::REG_QUIET_LIMIT, 16'hFFFF);
    write_reg(mbdd_pkg::REG_AUTO_RECAL, 16'h0001);
    full_rate = 1'b1;
    for (int i = 0; i < RUN_SAMPLES; i++) sample_queue.push_back(draw_sample());
    wait_drained();
    full_rate = 1'b0;
    write_reg(mbdd_pkg::REG_QUIET_LIMIT, 16'h0001);
    for (int i = 0; i < 6; i++) sample_queue.push_back(draw_sample());
    wait_drained();

    // Random phases, each with its own settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: set_over = 16'h8000;
        1: set_over = mbdd_pkg::OVER_LIMIT_RST;
        2: set_over = $urandom_range(0, 32768);
        default: set_over = $urandom_range(100, 4000);
      endcase
      case ($urandom_range(0, 3))
        0: set_calm = 16'h0000;
        1: set_calm = $urandom_range(0, set_over);
        2: set_calm = 16'h8000;
        default: set_calm = $urandom_range(50, 1200);
      endcase
      case ($urandom_range(0, 3))
        0: set_delta = 16'h0000;
        1: set_delta = 16'hFFFF;
        2: set_delta = $urandom_range(0, 2000);
        default: set_delta = $urandom_range(0, 120);
      endcase
      case ($urandom_range(0, 5))
        0: set_quiet = 16'h0000;
        1: set_quiet = 16'hFFFE;
        2: set_quiet = 16'hFFFF;
        default: set_quiet = $urandom_range(0, 25);
      endcase
      write_reg(mbdd_pkg::REG_OVER_LIMIT, set_over);
      write_reg(mbdd_pkg::REG_CALM_LIMIT, set_calm);
      write_reg(mbdd_pkg::REG_DELTA_LIMIT, set_delta);
      write_reg(mbdd_pkg::REG_QUIET_LIMIT, set_quiet);
      write_reg(mbdd_pkg::REG_AUTO_RECAL, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
      for (int i = 0; i < PHASE_SAMPLES; i++) sample_queue.push_back(draw_sample());
      wait_drained();
    end

    // Let any stray beat show up before the verdict.
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin : hang_guard
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: magnetic_baseline_disturbance_detector.f
src/mbdd_pkg.sv
src/magnetic_baseline_disturbance_detector.sv
tb/testbench.sv
